FILE: hw/rtl/jtd_pkg.sv
package jtd_pkg;

    // Score counter width and saturation ceiling
    localparam int SCORE_WIDTH = 16;
    localparam int OUT_SCORE_WIDTH = 16;

    typedef logic [SCORE_WIDTH-1:0] t_score;

    // Result encoding codes
    localparam logic [1:0] ENC_UNKNOWN = 2'd0;
    localparam logic [1:0] ENC_EUC     = 2'd1;
    localparam logic [1:0] ENC_SJIS    = 2'd2;
    localparam logic [1:0] ENC_UTF8    = 2'd3;

    // Window scanner flavors
    localparam logic KIND_EUC  = 1'b0;
    localparam logic KIND_UTF8 = 1'b1;

    // Score increments
    localparam logic [1:0] ADD_NONE   = 2'd0;
    localparam logic [1:0] ADD_PAIR   = 2'd2;
    localparam logic [1:0] ADD_TRIPLE = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
    } t_in_word;

    typedef struct packed {
        logic [1:0]                 encoding;
        logic [OUT_SCORE_WIDTH-1:0] sjis_score;
        logic [OUT_SCORE_WIDTH-1:0] euc_score;
        logic [OUT_SCORE_WIDTH-1:0] utf8_score;
    } t_out_word;

    // Add a small increment, stopping at the all-ones ceiling
    function automatic t_score sat_add(input t_score s, input logic [1:0] amt);
        logic [SCORE_WIDTH:0] sum;
        sum = {1'b0, s} + (SCORE_WIDTH+1)'(amt);
        if (sum[SCORE_WIDTH]) begin
            return '1;
        end
        return sum[SCORE_WIDTH-1:0];
    endfunction

    function automatic logic pair_match(input logic kind, input logic [7:0] a,
                                        input logic [7:0] b);
        if (kind == KIND_EUC) begin
            return ((a inside {[8'hA1:8'hFE]}) && (b inside {[8'hA1:8'hFE]})) ||
                   ((a == 8'h8E) && (b inside {[8'hA1:8'hDF]}));
        end
        return (a inside {[8'hC0:8'hDF]}) && (b inside {[8'h80:8'hBF]});
    endfunction

    function automatic logic triple_lead(input logic kind, input logic [7:0] a,
                                         input logic [7:0] b);
        if (kind == KIND_EUC) begin
            return (a == 8'h8F) && (b inside {[8'hA1:8'hFE]});
        end
        return (a inside {[8'hE0:8'hEF]}) && (b inside {[8'h80:8'hBF]});
    endfunction

    function automatic logic triple_tail(input logic kind, input logic [7:0] c);
        if (kind == KIND_EUC) begin
            return c inside {[8'hA1:8'hFE]};
        end
        return c inside {[8'h80:8'hBF]};
    endfunction

    function automatic logic sjis_lead(input logic [7:0] a);
        return (a inside {[8'h81:8'h9F]}) || (a inside {[8'hE0:8'hFC]});
    endfunction

    function automatic logic sjis_trail(input logic [7:0] b);
        return (b inside {[8'h40:8'h7E]}) || (b inside {[8'h80:8'hFC]});
    endfunction

endpackage

FILE: hw/rtl/jtd_sjis_scan.sv
module jtd_sjis_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_clear,
    input  logic [7:0]      i_byte,
    output jtd_pkg::t_score o_score
);
    import jtd_pkg::*;

    logic [7:0] r_held;
    logic       r_held_vld;
    t_score     r_score;
    logic [7:0] n_held;
    logic       n_held_vld;
    t_score     n_score;

    // Pair the held lead byte with the current byte, else hold the current byte
    always_comb begin
        n_held     = i_byte;
        n_held_vld = 1'b1;
        n_score    = r_score;
        if (r_held_vld && sjis_lead(r_held) && sjis_trail(i_byte)) begin
            n_held_vld = 1'b0;
            n_score    = sat_add(r_score, ADD_PAIR);
        end
    end

    assign o_score = n_score;

    // Advance on each word, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_held_vld <= 1'b0;
            r_score    <= '0;
        end else if (i_step) begin
            if (i_clear) begin
                r_held     <= '0;
                r_held_vld <= 1'b0;
                r_score    <= '0;
            end else begin
                r_held     <= n_held;
                r_held_vld <= n_held_vld;
                r_score    <= n_score;
            end
        end
    end

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_clear |=> !r_held_vld && (r_score == '0))
        else $error("sjis scanner not cleared after last word");

    a_score_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_clear |=> r_score >= $past(r_score))
        else $error("sjis score decreased");

    a_pair_drops_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_clear && (n_score != r_score) |=> !r_held_vld)
        else $error("sjis held byte kept after a match");

endmodule

FILE: hw/rtl/jtd_window_scan.sv
module jtd_window_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_kind,
    input  logic            i_step,
    input  logic            i_clear,
    input  logic [7:0]      i_byte,
    output jtd_pkg::t_score o_score
);
    import jtd_pkg::*;

    logic [7:0] r_win0;
    logic [7:0] r_win1;
    logic [1:0] r_fill;
    t_score     r_score;
    logic [7:0] n_win0;
    logic [7:0] n_win1;
    logic [1:0] n_fill;
    t_score     n_score;
    logic [1:0] w_add;
    logic [7:0] w_lead;
    logic       w_have_lead;

    // Try the triple tail first, then the pair and the triple lead
    always_comb begin
        n_win0      = r_win0;
        n_win1      = r_win1;
        n_fill      = r_fill;
        w_add       = ADD_NONE;
        w_lead      = r_win0;
        w_have_lead = (r_fill != 2'd0);
        if (r_fill[1] && triple_tail(i_kind, i_byte)) begin
            w_add  = ADD_TRIPLE;
            n_fill = 2'd0;
        end else begin
            // A failed triple moves on by one: the second byte leads
            if (r_fill[1]) begin
                w_lead = r_win1;
            end
            if (!w_have_lead) begin
                n_win0 = i_byte;
                n_fill = 2'd1;
            end else if (pair_match(i_kind, w_lead, i_byte)) begin
                w_add  = ADD_PAIR;
                n_fill = 2'd0;
            end else if (triple_lead(i_kind, w_lead, i_byte)) begin
                n_win0 = w_lead;
                n_win1 = i_byte;
                n_fill = 2'd2;
            end else begin
                n_win0 = i_byte;
                n_fill = 2'd1;
            end
        end
        n_score = sat_add(r_score, w_add);
    end

    assign o_score = n_score;

    // Advance on each word, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0  <= '0;
            r_win1  <= '0;
            r_fill  <= 2'd0;
            r_score <= '0;
        end else if (i_step) begin
            if (i_clear) begin
                r_win0  <= '0;
                r_win1  <= '0;
                r_fill  <= 2'd0;
                r_score <= '0;
            end else begin
                r_win0  <= n_win0;
                r_win1  <= n_win1;
                r_fill  <= n_fill;
                r_score <= n_score;
            end
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("window fill out of range");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_clear |=> (r_fill == 2'd0) && (r_score == '0))
        else $error("window scanner not cleared after last word");

    a_score_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_clear && (w_add != ADD_NONE) |=> r_fill == 2'd0)
        else $error("window kept bytes after a match");

endmodule

FILE: hw/rtl/japanese_text_encoding_detector_top.sv
// Result: the last text byte is registered at the input; once it proceeds, the result
//   word is registered and goes valid.
// Throughput: one text byte per cycle; input stalls only while a last byte waits
//   behind a result word that the output side has not yet taken.
// Reset: synchronous, active low; clears the input and result valid flags and all
//   scanner windows and scores. State also clears after each last byte.
module japanese_text_encoding_detector_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  jtd_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output jtd_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);
    import jtd_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word n_out;
    logic      w_proceed;
    logic      w_in_take;
    t_score    w_sjis;
    t_score    w_euc;
    t_score    w_utf8;

    // Hold a last byte while the previous result word is still stalled
    assign w_proceed  = r_in_valid && !(r_in.is_last && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !w_proceed;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || w_proceed) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_word;
        end
    end

    jtd_sjis_scan u_sjis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_proceed),
        .i_clear (r_in.is_last),
        .i_byte  (r_in.text_byte),
        .o_score (w_sjis)
    );

    jtd_window_scan u_euc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kind  (KIND_EUC),
        .i_step  (w_proceed),
        .i_clear (r_in.is_last),
        .i_byte  (r_in.text_byte),
        .o_score (w_euc)
    );

    jtd_window_scan u_utf8 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kind  (KIND_UTF8),
        .i_step  (w_proceed),
        .i_clear (r_in.is_last),
        .i_byte  (r_in.text_byte),
        .o_score (w_utf8)
    );

    // Pick the strict winner of EUC, Shift-JIS and UTF-8; a tie for the top gives unknown
    always_comb begin
        n_out.sjis_score = OUT_SCORE_WIDTH'(w_sjis);
        n_out.euc_score  = OUT_SCORE_WIDTH'(w_euc);
        n_out.utf8_score = OUT_SCORE_WIDTH'(w_utf8);
        if (w_euc > w_sjis && w_euc > w_utf8) begin
            n_out.encoding = ENC_EUC;
        end else if (w_sjis > w_euc && w_sjis > w_utf8) begin
            n_out.encoding = ENC_SJIS;
        end else if (w_utf8 > w_euc && w_utf8 > w_sjis) begin
            n_out.encoding = ENC_UTF8;
        end else begin
            n_out.encoding = ENC_UNKNOWN;
        end
    end

    // Load the result word on a last byte, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proceed && r_in.is_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && r_in.is_last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !(w_proceed && r_in.is_last))
        else $error("result word overwritten while stalled");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proceed && r_in.is_last |=> r_out_valid)
        else $error("no result word after last byte");

    a_plain_byte_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_in.is_last |-> w_proceed)
        else $error("non-last byte held back");

endmodule

FILE: test/jtd_result_checker.sv
`timescale 1ns / 1ps

module jtd_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  jtd_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  jtd_pkg::t_out_word i_out_word,
    output int                 o_mismatch_count,
    output int                 o_results_owed
);

    localparam int     OW         = jtd_pkg::OUT_SCORE_WIDTH;
    localparam longint SCORE_CEIL = (longint'(1) << jtd_pkg::SCORE_WIDTH) - 1;

    // Score slots
    localparam int SC_SJIS = 0;
    localparam int SC_EUC  = 1;
    localparam int SC_UTF8 = 2;

    // Shadow scanner state
    logic [7:0] sjis_lead_byte;
    logic       sjis_lead_held;
    logic [7:0] pend_bytes [2][2];
    int         pend_count [2];
    longint     score [3];

    jtd_pkg::t_out_word verdicts_due [$];

    function automatic logic between(input logic [7:0] v, input logic [7:0] lo,
                                     input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Two-byte match for the EUC or UTF-8 scanner
    function automatic logic pair_ok(input logic kind, input logic [7:0] a,
                                     input logic [7:0] b);
        if (kind == jtd_pkg::KIND_UTF8) begin
            return between(a, 8'hC0, 8'hDF) && between(b, 8'h80, 8'hBF);
        end
        if (a == 8'h8E) begin
            return between(b, 8'hA1, 8'hDF);
        end
        return between(a, 8'hA1, 8'hFE) && between(b, 8'hA1, 8'hFE);
    endfunction

    // First two bytes of a three-byte sequence
    function automatic logic opens_triple(input logic kind, input logic [7:0] a,
                                          input logic [7:0] b);
        if (kind == jtd_pkg::KIND_UTF8) begin
            return between(a, 8'hE0, 8'hEF) && between(b, 8'h80, 8'hBF);
        end
        return (a == 8'h8F) && between(b, 8'hA1, 8'hFE);
    endfunction

    function automatic logic closes_triple(input logic kind, input logic [7:0] c);
        if (kind == jtd_pkg::KIND_UTF8) begin
            return between(c, 8'h80, 8'hBF);
        end
        return between(c, 8'hA1, 8'hFE);
    endfunction

    task automatic credit(input int slot, input int amount);
        score[slot] = (score[slot] + amount > SCORE_CEIL) ? SCORE_CEIL
                                                          : score[slot] + amount;
    endtask

    task automatic clear_scan();
        sjis_lead_byte = 8'h00;
        sjis_lead_held = 1'b0;
        for (int k = 0; k < 2; k++) begin
            pend_bytes[k][0] = 8'h00;
            pend_bytes[k][1] = 8'h00;
            pend_count[k]    = 0;
        end
        for (int s = 0; s < 3; s++) begin
            score[s] = 0;
        end
    endtask

    // Pair a held lead byte with a trail byte, else hold the new byte
    task automatic scan_sjis(input logic [7:0] b);
        logic lead_ok;
        logic trail_ok;
        lead_ok  = between(sjis_lead_byte, 8'h81, 8'h9F) ||
                   between(sjis_lead_byte, 8'hE0, 8'hFC);
        trail_ok = between(b, 8'h40, 8'h7E) || between(b, 8'h80, 8'hFC);
        if (sjis_lead_held && lead_ok && trail_ok) begin
            credit(SC_SJIS, 2);
            sjis_lead_held = 1'b0;
        end else begin
            sjis_lead_byte = b;
            sjis_lead_held = 1'b1;
        end
    endtask

    // Advance one windowed scanner by a byte
    task automatic scan_window(input logic kind, input logic [7:0] b);
        int  k;
        int  slot;
        logic done;
        k    = (kind == jtd_pkg::KIND_UTF8) ? 1 : 0;
        slot = (kind == jtd_pkg::KIND_UTF8) ? SC_UTF8 : SC_EUC;
        done = 1'b0;
        if (pend_count[k] >= 2) begin
            if (closes_triple(kind, b)) begin
                credit(slot, 3);
                pend_count[k] = 0;
                done = 1'b1;
            end else begin
                // drop the first byte, the second becomes the lead
                pend_bytes[k][0] = pend_bytes[k][1];
                pend_count[k]    = 1;
            end
        end
        if (!done) begin
            if (pend_count[k] == 0) begin
                pend_bytes[k][0] = b;
                pend_count[k]    = 1;
            end else if (pair_ok(kind, pend_bytes[k][0], b)) begin
                credit(slot, 2);
                pend_count[k] = 0;
            end else if (opens_triple(kind, pend_bytes[k][0], b)) begin
                pend_bytes[k][1] = b;
                pend_count[k]    = 2;
            end else begin
                pend_bytes[k][0] = b;
                pend_count[k]    = 1;
            end
        end
    endtask

    // Feed one text byte; on the last byte queue the predicted verdict
    task automatic scan_byte(input logic [7:0] b, input logic last);
        jtd_pkg::t_out_word verdict;
        longint s;
        longint e;
        longint u;
        scan_sjis(b);
        scan_window(jtd_pkg::KIND_EUC, b);
        scan_window(jtd_pkg::KIND_UTF8, b);
        if (last) begin
            s = score[SC_SJIS];
            e = score[SC_EUC];
            u = score[SC_UTF8];
            if (e > s && e > u) begin
                verdict.encoding = jtd_pkg::ENC_EUC;
            end else if (s > e && s > u) begin
                verdict.encoding = jtd_pkg::ENC_SJIS;
            end else if (u > e && u > s) begin
                verdict.encoding = jtd_pkg::ENC_UTF8;
            end else begin
                verdict.encoding = jtd_pkg::ENC_UNKNOWN;
            end
            verdict.sjis_score = OW'(s);
            verdict.euc_score  = OW'(e);
            verdict.utf8_score = OW'(u);
            verdicts_due.insert(verdicts_due.size(), verdict);
            clear_scan();
        end
    endtask

    task automatic flag_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        o_mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            flag_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
        end
    endtask

    // Check result words in order, then advance the predictor
    always @(posedge i_clk) begin : watch
        jtd_pkg::t_out_word due;
        if (!i_rst_n) begin
            clear_scan();
            verdicts_due.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdicts_due.size() == 0) begin
                    flag_mismatch($sformatf("result word %h with no text pending",
                                            i_out_word));
                end else begin
                    due = verdicts_due.pop_front();
                    compare_field("encoding", 32'(due.encoding), 32'(i_out_word.encoding));
                    compare_field("sjis_score", 32'(due.sjis_score),
                                  32'(i_out_word.sjis_score));
                    compare_field("euc_score", 32'(due.euc_score),
                                  32'(i_out_word.euc_score));
                    compare_field("utf8_score", 32'(due.utf8_score),
                                  32'(i_out_word.utf8_score));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                scan_byte(i_in_word.text_byte, i_in_word.is_last);
            end
        end
        o_results_owed = verdicts_due.size();
    end

endmodule

FILE: test/tb_japanese_text_encoding_detector_top.sv
`timescale 1ns / 1ps

module tb_japanese_text_encoding_detector_top;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          PHASE_BYTES = 456;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    jtd_pkg::t_in_word  in_word   = '0;
    logic               in_stall;
    logic               out_valid;
    jtd_pkg::t_out_word out_word;
    logic               out_stall = 1'b0;

    int          mismatch_count;
    int          results_owed;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          phase_bytes;
    int unsigned cycle_count    = 0;
    logic [7:0]  text_buf [$];

    japanese_text_encoding_detector_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_word  (in_word),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_word (out_word),
        .i_out_stall(out_stall)
    );

    jtd_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_word       (in_word),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_word      (out_word),
        .o_mismatch_count(mismatch_count),
        .o_results_owed  (results_owed)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stall the result side at random
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [7:0] pick(input logic [7:0] lo, input logic [7:0] hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // Append one byte to the text being built
    task automatic add_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endtask

    // Offer one word, holding it until it is taken
    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{text_byte: b, is_last: last};
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
        phase_bytes++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_word(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    // Append one sequence: mostly well formed, some noise and cut-off leads
    task automatic add_sequence();
        int r;
        r = $urandom_range(99);
        if (r < 14) begin
            add_byte($urandom_range(1) ? pick(8'h81, 8'h9F) : pick(8'hE0, 8'hFC));
            add_byte($urandom_range(1) ? pick(8'h40, 8'h7E) : pick(8'h80, 8'hFC));
        end else if (r < 28) begin
            add_byte(pick(8'hA1, 8'hFE));
            add_byte(pick(8'hA1, 8'hFE));
        end else if (r < 38) begin
            add_byte(8'h8E);
            add_byte(pick(8'hA1, 8'hDF));
        end else if (r < 50) begin
            add_byte(8'h8F);
            add_byte(pick(8'hA1, 8'hFE));
            add_byte(pick(8'hA1, 8'hFE));
        end else if (r < 64) begin
            add_byte(pick(8'hC0, 8'hDF));
            add_byte(pick(8'h80, 8'hBF));
        end else if (r < 78) begin
            add_byte(pick(8'hE0, 8'hEF));
            add_byte(pick(8'h80, 8'hBF));
            add_byte(pick(8'h80, 8'hBF));
        end else if (r < 90) begin
            add_byte(pick(8'h00, 8'hFF));
        end else begin
            case ($urandom_range(2))
                0: add_byte(8'h8F);
                1: add_byte(pick(8'hE0, 8'hEF));
                default: add_byte(pick(8'hC0, 8'hDF));
            endcase
        end
    endtask

    task automatic set_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_bytes    = 0;
    endtask

    // Hold the input side until every verdict is back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        int n_seq;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed texts: range edges, each sequence kind, short and cut-off texts
        set_phase(0, 0);
        text_buf = '{8'h00};               send_text();
        text_buf = '{8'hFF};               send_text();
        text_buf = '{8'h81, 8'h40};        send_text();
        text_buf = '{8'hFC, 8'hFC};        send_text();
        text_buf = '{8'hA1, 8'hFE};        send_text();
        text_buf = '{8'h8E, 8'hDF};        send_text();
        text_buf = '{8'h8F, 8'hA1, 8'hFE}; send_text();
        text_buf = '{8'hC0, 8'h80};        send_text();
        text_buf = '{8'hE0, 8'h80, 8'hBF}; send_text();
        text_buf = '{8'hEF, 8'hBF, 8'h80}; send_text();
        text_buf = '{8'hE0, 8'h80};        send_text();
        text_buf = '{8'h7F, 8'h9F, 8'h7E}; send_text();
        drain();

        // Random texts under each idling mix
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_phase(0, 0);
                1: set_phase(59, 0);
                2: set_phase(0, 59);
                default: set_phase(14, 14);
            endcase
            while (phase_bytes < PHASE_BYTES) begin
                n_seq = ($urandom_range(19) == 0) ? $urandom_range(80, 40)
                                                  : $urandom_range(12, 1);
                for (int s = 0; s < n_seq; s++) begin
                    add_sequence();
                end
                send_text();
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
